// ----- hw/rtl/klvt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package klvt_pkg;

   // action codes
   localparam logic [1:0] ACT_UPDATE = 2'd0;
   localparam logic [1:0] ACT_ADD    = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;
   localparam logic [1:0] ACT_LOOKUP = 2'd3;

   // result codes
   localparam logic [1:0] RC_OK        = 2'd0;
   localparam logic [1:0] RC_NOT_FOUND = 2'd1;
   localparam logic [1:0] RC_NO_SPACE  = 2'd2;

   // register map
   localparam int         CSR_ADDR_BITS        = 3;
   localparam logic       CSR_IDX_UNREG_STATUS = 1'b0;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] entry_key;
      logic [63:0] entry_payload;
      logic [7:0]  entry_status;
      logic [31:0] entry_time_ms;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_code;
      logic [63:0] found_payload;
      logic [7:0]  found_status;
      logic [31:0] found_time_ms;
      logic [4:0]  entry_count;
      logic [31:0] snapshot_time_ms;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_APPLY,
      ST_SHIFT,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/keyed_latest_value_table_core.sv -----
// keyed latest-value table
// Holds up to MAX_ENTRIES records (key, payload, status, time) packed in
// slots 0 .. count-1 of one synchronous RAM. Each request word on the req
// channel carries an action (update, add, remove, lookup) and a key; the
// rsp channel returns exactly one word per request with a result code,
// the looked-up fields, the record count and the last-change time.
// Sequence: the key search reads one slot per cycle from slot 0 up and
// stops at the first hit or after the last slot below the count; the
// action is then applied, and a remove moves each later record down one
// slot per cycle before the result is delivered.
// One request is in work at a time; req_stall is high from acceptance until
// its result is loaded into the output register, and the next request is
// taken once the engine is back in idle. A result waiting under rsp_stall
// does not block the next request from being accepted and searched; only
// the hand-off of that next result waits.
// Reset clears the count, the snapshot time and the unregistered_status
// register; RAM contents are never read beyond the count, so no clearing
// pass is needed. The csr APB port writes unregistered_status where paddr[2] is 0.
`timescale 1ns / 1ps
`default_nettype none

module keyed_latest_value_table_core #(
   parameter int MAX_ENTRIES  = 16,
   parameter int KEY_BITS     = 64,
   parameter int PAYLOAD_BITS = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire klvt_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output klvt_pkg::rsp_type                       rsp_data,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [klvt_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [31:0]                        pwdata,
   output logic      [31:0]                        prdata,
   output logic                                    pready
);
   import klvt_pkg::*;

   logic [7:0] unreg_status_ff, unreg_status_in;
   logic       csr_wr;
   logic       csr_hit;

   // register access
   assign pready  = 1'b1;
   assign csr_hit = (paddr[CSR_ADDR_BITS-1] == CSR_IDX_UNREG_STATUS);
   assign csr_wr  = psel && penable && pwrite && pready && csr_hit;

   always_comb begin
      unreg_status_in = unreg_status_ff;
      if (csr_wr) begin
         unreg_status_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unreg_status_ff <= '0;
      end else begin
         unreg_status_ff <= unreg_status_in;
      end
   end

   assign prdata = csr_hit ? {24'd0, unreg_status_ff} : 32'd0;

   klvt_engine #(
      .MAX_ENTRIES  (MAX_ENTRIES),
      .KEY_BITS     (KEY_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .unreg_status (unreg_status_ff)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/klvt_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module klvt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/klvt_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none

module klvt_engine #(
   parameter int MAX_ENTRIES  = 16,
   parameter int KEY_BITS     = 64,
   parameter int PAYLOAD_BITS = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire klvt_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output klvt_pkg::rsp_type      rsp_data,
   input  wire logic [7:0]        unreg_status
);
   import klvt_pkg::*;

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int RW = KEY_BITS + PAYLOAD_BITS + 40;

   state_type             state_ff, state_in;
   req_type               item_ff, item_in;
   logic [CW-1:0]         scan_ff, scan_in;
   logic                  pend_ff, pend_in;
   logic [CW-1:0]         pidx_ff, pidx_in;
   logic                  hit_ff, hit_in;
   logic [AW-1:0]         hidx_ff, hidx_in;
   logic [PAYLOAD_BITS-1:0] fpay_ff, fpay_in;
   logic [7:0]            fsts_ff, fsts_in;
   logic [31:0]           ftim_ff, ftim_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [31:0]           snap_ff, snap_in;
   logic [1:0]            rc_ff, rc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [RW-1:0]         ram_wdata;
   logic [AW-1:0]         ram_raddr;
   logic [RW-1:0]         ram_rdata;

   logic [KEY_BITS-1:0]     rd_key;
   logic [PAYLOAD_BITS-1:0] rd_pay;
   logic [7:0]              rd_sts;
   logic [31:0]             rd_tim;
   logic [KEY_BITS-1:0]     item_key;
   logic                    has_room;
   logic                    out_free;
   logic [CW-1:0]           shift_dst;

   // record layout: key, payload, status, time
   assign rd_key   = ram_rdata[RW-1 -: KEY_BITS];
   assign rd_pay   = ram_rdata[PAYLOAD_BITS+39 -: PAYLOAD_BITS];
   assign rd_sts   = ram_rdata[39:32];
   assign rd_tim   = ram_rdata[31:0];
   assign item_key = item_ff.entry_key[KEY_BITS-1:0];
   assign has_room = (count_ff < CW'(MAX_ENTRIES));
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign shift_dst = pidx_ff - CW'(1);

   klvt_ram #(
      .WIDTH (RW),
      .DEPTH (MAX_ENTRIES),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         snap_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         snap_ff      <= snap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff <= item_in;
      scan_ff <= scan_in;
      pidx_ff <= pidx_in;
      hit_ff  <= hit_in;
      hidx_ff <= hidx_in;
      fpay_ff <= fpay_in;
      fsts_ff <= fsts_in;
      ftim_ff <= ftim_in;
      rc_ff   <= rc_in;
      rsp_ff  <= rsp_in;
   end

   // sequencer: search, apply, shift on remove, deliver
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      pidx_in      = pidx_ff;
      hit_in       = hit_ff;
      hidx_in      = hidx_ff;
      fpay_in      = fpay_ff;
      fsts_in      = fsts_ff;
      ftim_in      = ftim_ff;
      count_in     = count_ff;
      snap_in      = snap_ff;
      rc_in        = rc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_we       = 1'b0;
      ram_waddr    = hidx_ff;
      ram_wdata    = '0;
      ram_raddr    = scan_ff[AW-1:0];
      req_stall    = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               scan_in  = '0;
               pend_in  = 1'b0;
               hit_in   = 1'b0;
               rc_in    = RC_OK;
               state_in = ST_SEARCH;
            end
         end

         ST_SEARCH: begin
            // stream reads of slots below the count, compare in the next cycle
            pend_in = 1'b0;
            if (scan_ff < count_ff) begin
               scan_in = scan_ff + CW'(1);
               pend_in = 1'b1;
               pidx_in = scan_ff;
            end
            if (pend_ff && rd_key == item_key) begin
               hit_in   = 1'b1;
               hidx_in  = pidx_ff[AW-1:0];
               fpay_in  = rd_pay;
               fsts_in  = rd_sts;
               ftim_in  = rd_tim;
               pend_in  = 1'b0;
               state_in = ST_APPLY;
            end else if (!pend_ff && scan_ff >= count_ff) begin
               hit_in   = 1'b0;
               state_in = ST_APPLY;
            end
         end

         ST_APPLY: begin
            state_in = ST_DONE;
            case (item_ff.action)
               ACT_UPDATE: begin
                  ram_wdata = {item_key, item_ff.entry_payload[PAYLOAD_BITS-1:0],
                               item_ff.entry_status, item_ff.entry_time_ms};
                  if (hit_ff) begin
                     ram_we = 1'b1;
                  end else if (has_room) begin
                     ram_we    = 1'b1;
                     ram_waddr = count_ff[AW-1:0];
                     count_in  = count_ff + CW'(1);
                  end else begin
                     rc_in = RC_NO_SPACE;
                  end
                  snap_in = item_ff.now_ms;
               end
               ACT_ADD: begin
                  ram_wdata = {item_key, {PAYLOAD_BITS{1'b0}}, unreg_status,
                               item_ff.now_ms};
                  if (!hit_ff && has_room) begin
                     ram_we    = 1'b1;
                     ram_waddr = count_ff[AW-1:0];
                     count_in  = count_ff + CW'(1);
                     snap_in   = item_ff.now_ms;
                  end
               end
               ACT_REMOVE: begin
                  if (hit_ff) begin
                     scan_in  = CW'(hidx_ff) + CW'(1);
                     pend_in  = 1'b0;
                     state_in = ST_SHIFT;
                  end else begin
                     rc_in = RC_NOT_FOUND;
                  end
               end
               default: begin
                  if (!hit_ff) begin
                     rc_in = RC_NOT_FOUND;
                  end
               end
            endcase
         end

         ST_SHIFT: begin
            // read slot i+1, write it to slot i on the next cycle
            pend_in = 1'b0;
            if (scan_ff < count_ff) begin
               scan_in = scan_ff + CW'(1);
               pend_in = 1'b1;
               pidx_in = scan_ff;
            end
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = shift_dst[AW-1:0];
               ram_wdata = ram_rdata;
            end
            if (!pend_ff && scan_ff >= count_ff) begin
               count_in = count_ff - CW'(1);
               snap_in  = item_ff.now_ms;
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            // hand the result to the output register once it is free
            if (out_free) begin
               rsp_in.result_code      = rc_ff;
               rsp_in.entry_count      = 5'(count_ff);
               rsp_in.snapshot_time_ms = snap_ff;
               if (item_ff.action == ACT_LOOKUP && hit_ff) begin
                  rsp_in.found_payload = 64'(fpay_ff);
                  rsp_in.found_status  = fsts_ff;
                  rsp_in.found_time_ms = ftim_ff;
               end else begin
                  rsp_in.found_payload = '0;
                  rsp_in.found_status  = '0;
                  rsp_in.found_time_ms = '0;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
